// ----- design/rqc_pkg.sv -----
// Shared types, constants and the arctangent table for the rotated quad corner core.
// No dependencies; every other design file refers to it by scoped names.
package rqc_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int XY_W         = 33;  // CORDIC x/y, 30 fraction bits plus headroom
  localparam int Z_W          = 32;  // residual angle, 2^32 per turn
  localparam int COORD_W      = 16;
  localparam int SIZE_W       = 16;
  localparam int OUT_W        = 18;
  localparam int PROD_W       = XY_W + SIZE_W + 1;
  localparam int SUM_W        = 52;
  localparam int SHIFT_OUT    = 31;
  localparam int ANGLE_BITS_DEF = 16;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [Z_W-1:0]         HALF_QUAD   = 32'h2000_0000;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_RECT_WIDTH  = 1'b0,
    REG_RECT_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_BR = 2'd3
  } corner_t;

  // data carried from cell to cell along the rotation chain
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [1:0]                quad;
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
  } cell_t;

  // arctangent of 2^-idx, in 2^32-per-turn units
  function automatic logic [Z_W-1:0] atan_step(input int idx);
    logic [Z_W-1:0] val;
    case (idx)
      0:  val = 32'd536870912;
      1:  val = 32'd316933406;
      2:  val = 32'd167458907;
      3:  val = 32'd85004756;
      4:  val = 32'd42667331;
      5:  val = 32'd21354465;
      6:  val = 32'd10679838;
      7:  val = 32'd5340245;
      8:  val = 32'd2670163;
      9:  val = 32'd1335087;
      10: val = 32'd667544;
      11: val = 32'd333772;
      12: val = 32'd166886;
      13: val = 32'd83443;
      14: val = 32'd41722;
      15: val = 32'd20861;
      16: val = 32'd10430;
      17: val = 32'd5215;
      18: val = 32'd2608;
      19: val = 32'd1304;
      20: val = 32'd652;
      21: val = 32'd326;
      22: val = 32'd163;
      23: val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- design/rqc_cordic_cell.sv -----
// One rotation-mode CORDIC iteration, registered; cells chain into the sin/cos pipe.
// Depends on rqc_pkg (cell_t, atan_step).
module rqc_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  rqc_pkg::cell_t d_in,
  output logic          vld_out,
  output rqc_pkg::cell_t d_out
);

  localparam logic [rqc_pkg::Z_W-1:0] ATAN = rqc_pkg::atan_step(STEP);

  rqc_pkg::cell_t                      d_nxt;
  logic signed [rqc_pkg::XY_W-1:0]     xs;
  logic signed [rqc_pkg::XY_W-1:0]     ys;
  logic                                vld_r;
  rqc_pkg::cell_t                      d_r;

  // arithmetic shift gives the floor, as the checker's integer CORDIC does
  assign xs = $signed(d_in.x) >>> STEP;
  assign ys = $signed(d_in.y) >>> STEP;

  always_comb begin
    d_nxt = d_in;
    if (!d_in.z[rqc_pkg::Z_W-1]) begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.z = d_in.z - $signed(ATAN);
    end else begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.z = d_in.z + $signed(ATAN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

// ----- design/rqc_corner_emit.sv -----
// Quadrant fold, size products and the four-corner sequencer with rounding.
// Depends on rqc_pkg (cell_t, corner_t, widths).
module rqc_corner_emit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               vld_in,
  input  rqc_pkg::cell_t                     d_in,
  input  logic [rqc_pkg::SIZE_W-1:0]         rect_width,
  input  logic [rqc_pkg::SIZE_W-1:0]         rect_height,
  output logic                               out_valid,
  output logic [1:0]                         out_corner_index,
  output logic signed [rqc_pkg::OUT_W-1:0]   out_corner_x,
  output logic signed [rqc_pkg::OUT_W-1:0]   out_corner_y,
  output logic                               out_last_corner
);

  localparam int XY_W  = rqc_pkg::XY_W;
  localparam int PW    = rqc_pkg::PROD_W;
  localparam int SW    = rqc_pkg::SUM_W;
  localparam int RW    = SW - rqc_pkg::SHIFT_OUT;
  localparam int OW    = rqc_pkg::OUT_W;
  localparam logic signed [RW-1:0] OUT_MAX = RW'((1 <<< (OW - 1)) - 1);
  localparam logic signed [RW-1:0] OUT_MIN = -RW'(1 <<< (OW - 1));

  // quadrant fold stage
  logic                    fix_vld_r;
  logic signed [XY_W-1:0]  cos_r, sin_r, cos_nxt, sin_nxt;
  logic signed [rqc_pkg::COORD_W-1:0] fcx_r, fcy_r;

  always_comb begin
    case (d_in.quad)
      2'd0: begin
        cos_nxt = d_in.x;
        sin_nxt = d_in.y;
      end
      2'd1: begin
        cos_nxt = -d_in.y;
        sin_nxt = d_in.x;
      end
      2'd2: begin
        cos_nxt = -d_in.x;
        sin_nxt = -d_in.y;
      end
      default: begin
        cos_nxt = d_in.y;
        sin_nxt = -d_in.x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_vld_r <= 1'b0;
    end else begin
      fix_vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
    fcx_r <= d_in.cx;
    fcy_r <= d_in.cy;
  end

  // products, held for the four corner beats
  logic signed [PW-1:0] wc_r, ws_r, hc_r, hs_r;
  logic signed [SW-1:0] base_x_r, base_y_r;
  logic signed [rqc_pkg::SIZE_W:0] w_s, h_s;

  assign w_s = $signed({1'b0, rect_width});
  assign h_s = $signed({1'b0, rect_height});

  always_ff @(posedge clk) begin
    if (fix_vld_r) begin
      wc_r     <= PW'(w_s) * PW'(cos_r);
      ws_r     <= PW'(w_s) * PW'(sin_r);
      hc_r     <= PW'(h_s) * PW'(cos_r);
      hs_r     <= PW'(h_s) * PW'(sin_r);
      // centre term with the rounding half folded in
      base_x_r <= (SW'(fcx_r) <<< rqc_pkg::SHIFT_OUT) + (SW'(1) <<< (rqc_pkg::SHIFT_OUT - 1));
      base_y_r <= (SW'(fcy_r) <<< rqc_pkg::SHIFT_OUT) + (SW'(1) <<< (rqc_pkg::SHIFT_OUT - 1));
    end
  end

  // corner sequencer
  logic                  act_r, act_nxt;
  rqc_pkg::corner_t      k_r, k_nxt;

  always_comb begin
    act_nxt = act_r;
    k_nxt   = k_r;
    if (fix_vld_r) begin
      act_nxt = 1'b1;
      k_nxt   = rqc_pkg::CORNER_TL;
    end else if (act_r) begin
      k_nxt = rqc_pkg::corner_t'(k_r + 2'd1);
      if (k_r == rqc_pkg::CORNER_BR) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      k_r   <= rqc_pkg::CORNER_TL;
    end else begin
      act_r <= act_nxt;
      k_r   <= k_nxt;
    end
  end

  // corner sums: left/top take the negative offset
  logic signed [SW-1:0] t_wc, t_ws, t_hc, t_hs, vx, vy;
  logic signed [RW-1:0] rx, ry;
  logic signed [OW-1:0] sat_x, sat_y;

  assign t_wc = k_r[0] ? SW'(wc_r) : -SW'(wc_r);
  assign t_ws = k_r[0] ? SW'(ws_r) : -SW'(ws_r);
  assign t_hc = k_r[1] ? SW'(hc_r) : -SW'(hc_r);
  assign t_hs = k_r[1] ? SW'(hs_r) : -SW'(hs_r);
  assign vx   = base_x_r + t_wc + t_hs;
  assign vy   = base_y_r + t_hc - t_ws;
  assign rx   = vx[SW-1:rqc_pkg::SHIFT_OUT];
  assign ry   = vy[SW-1:rqc_pkg::SHIFT_OUT];

  always_comb begin
    if (rx > OUT_MAX)      sat_x = OUT_MAX[OW-1:0];
    else if (rx < OUT_MIN) sat_x = OUT_MIN[OW-1:0];
    else                   sat_x = rx[OW-1:0];
    if (ry > OUT_MAX)      sat_y = OUT_MAX[OW-1:0];
    else if (ry < OUT_MIN) sat_y = OUT_MIN[OW-1:0];
    else                   sat_y = ry[OW-1:0];
  end

  logic                  ov_r;
  logic [1:0]            oidx_r;
  logic signed [OW-1:0]  ox_r, oy_r;
  logic                  olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    oidx_r  <= k_r;
    ox_r    <= sat_x;
    oy_r    <= sat_y;
    olast_r <= act_r && (k_r == rqc_pkg::CORNER_BR);
  end

  assign out_valid        = ov_r;
  assign out_corner_index = oidx_r;
  assign out_corner_x     = ox_r;
  assign out_corner_y     = oy_r;
  assign out_last_corner  = olast_r;

  // a new item must never land on a run that is still mid-way
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    fix_vld_r |-> (!act_r || k_r == rqc_pkg::CORNER_BR))
    else $error("corner run overrun");

  // a run, once started, yields its remaining corners on consecutive beats
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && k_r != rqc_pkg::CORNER_BR) |=> act_r)
    else $error("corner run broken");

endmodule

// ----- design/rotated_quad_corners_core.sv -----
// Top level of the rotated quad corner core: angle split, CORDIC cell chain, corner emitter.
// Depends on rqc_pkg, rqc_cordic_cell and rqc_corner_emit.
//
//  channel   handshake              payload
//  input     start / busy           in_center_x, in_center_y, in_rotation
//  result    out_valid (strobe)     out_corner_index, out_corner_x, out_corner_y, out_last_corner
//  config    cfg_we                 cfg_addr, cfg_wdata
//
// Items are spaced by the issue gap counter: the corner emitter gives one beat per cycle,
// so busy stays high after each accept until the counter has run down.
// Items overlap in the 24-cell CORDIC chain; the first corner passes the input register, the cells,
// the fold register, the product and sequencer registers and the output register; the other three follow.
// rst_n is synchronous and clears the pipe valids, sequencer and size registers.
// Results are never held off; each beat is on the ports for one cycle only.
module rotated_quad_corners_core #(
  parameter int ANGLE_BITS = rqc_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rqc_pkg::COORD_W-1:0]  in_center_x,
  input  logic signed [rqc_pkg::COORD_W-1:0]  in_center_y,
  input  logic [ANGLE_BITS-1:0]               in_rotation,
  output logic                                out_valid,
  output logic [1:0]                          out_corner_index,
  output logic signed [rqc_pkg::OUT_W-1:0]    out_corner_x,
  output logic signed [rqc_pkg::OUT_W-1:0]    out_corner_y,
  output logic                                out_last_corner,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_addr,
  input  logic [rqc_pkg::SIZE_W-1:0]          cfg_wdata
);

  localparam int N  = rqc_pkg::CORDIC_STEPS;
  localparam int ZW = rqc_pkg::Z_W;

  // configuration
  logic [rqc_pkg::SIZE_W-1:0] rect_width_r, rect_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_width_r  <= '0;
      rect_height_r <= '0;
    end else if (cfg_we) begin
      case (rqc_pkg::cfg_reg_t'(cfg_addr))
        rqc_pkg::REG_RECT_WIDTH:  rect_width_r  <= cfg_wdata;
        rqc_pkg::REG_RECT_HEIGHT: rect_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // issue spacing
  logic       accept;
  logic [1:0] gap_r, gap_nxt;

  assign accept = start && !busy;
  assign busy   = (gap_r != 2'd0);

  always_comb begin
    gap_nxt = gap_r;
    if (accept)            gap_nxt = 2'd3;
    else if (gap_r != 2'd0) gap_nxt = gap_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
    end else begin
      gap_r <= gap_nxt;
    end
  end

  // angle split into quadrant and signed residual
  logic [ZW-1:0] ang, ang_rnd, z_res;
  logic [1:0]    quad;

  assign ang     = {in_rotation, {(ZW - ANGLE_BITS){1'b0}}};
  assign ang_rnd = ang + rqc_pkg::HALF_QUAD;
  assign quad    = ang_rnd[ZW-1:ZW-2];
  assign z_res   = ang - {quad, {(ZW - 2){1'b0}}};

  logic            vld_c [N+1];
  rqc_pkg::cell_t  dat_c [N+1];
  logic            in_vld_r;
  rqc_pkg::cell_t  in_dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_dat_r.cx   <= in_center_x;
    in_dat_r.cy   <= in_center_y;
    in_dat_r.quad <= quad;
    in_dat_r.x    <= rqc_pkg::CORDIC_GAIN;
    in_dat_r.y    <= '0;
    in_dat_r.z    <= $signed(z_res);
  end

  assign vld_c[0] = in_vld_r;
  assign dat_c[0] = in_dat_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rqc_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_in (vld_c[i]),
      .d_in   (dat_c[i]),
      .vld_out(vld_c[i+1]),
      .d_out  (dat_c[i+1])
    );
  end

  rqc_corner_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .vld_in          (vld_c[N]),
    .d_in            (dat_c[N]),
    .rect_width      (rect_width_r),
    .rect_height     (rect_height_r),
    .out_valid       (out_valid),
    .out_corner_index(out_corner_index),
    .out_corner_x    (out_corner_x),
    .out_corner_y    (out_corner_y),
    .out_last_corner (out_last_corner)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy ##1 busy ##1 busy)
    else $error("accept spacing too short");

  a_last_on_br: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_corner |-> (out_valid && out_corner_index == rqc_pkg::CORNER_BR))
    else $error("last beat not on bottom-right corner");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_corner_index != rqc_pkg::CORNER_BR) |=>
      (out_valid && out_corner_index == $past(out_corner_index) + 2'd1))
    else $error("corner beats out of order");

endmodule

// ----- verif/rqc_corner_checker.sv -----
// Corner checker for rotated_quad_corners_core: watches the item and config ports, predicts
// the four corner beats of each accepted item with its own integer CORDIC, checks them in order.
// Depends on rqc_pkg for port widths and the register and corner codes.
`timescale 1ns / 1ps
module rqc_corner_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [rqc_pkg::COORD_W-1:0]  in_center_x,
  input  logic signed [rqc_pkg::COORD_W-1:0]  in_center_y,
  input  logic [rqc_pkg::ANGLE_BITS_DEF-1:0]  in_rotation,
  input  logic                                out_valid,
  input  logic [1:0]                          out_corner_index,
  input  logic signed [rqc_pkg::OUT_W-1:0]    out_corner_x,
  input  logic signed [rqc_pkg::OUT_W-1:0]    out_corner_y,
  input  logic                                out_last_corner,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_addr,
  input  logic [rqc_pkg::SIZE_W-1:0]          cfg_wdata,
  output int                                  fail_count,
  output int                                  corners_due,
  output int                                  items_seen,
  output int                                  beats_seen
);

  localparam int ANG_W = rqc_pkg::ANGLE_BITS_DEF;

  typedef struct packed {
    rqc_pkg::corner_t                  idx;
    logic signed [rqc_pkg::OUT_W-1:0]  x;
    logic signed [rqc_pkg::OUT_W-1:0]  y;
    logic                              last;
  } corner_beat_t;

  // arctan(2^-i) in 2^32-per-turn units
  longint arctan_units [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic [rqc_pkg::SIZE_W-1:0] width_q  = '0;
  logic [rqc_pkg::SIZE_W-1:0] height_q = '0;
  corner_beat_t               corners_expected [$];
  corner_beat_t               want;

  initial begin
    fail_count  = 0;
    corners_due = 0;
    items_seen  = 0;
    beats_seen  = 0;
  end

  // cos/sin scaled by 2^30; residual angle folded into +-1/8 turn, then quadrant applied
  function automatic void cordic_sin_cos(input logic [31:0] turn, output longint cos_v,
                                         output longint sin_v);
    logic [31:0] biased;
    logic [31:0] resid;
    logic [1:0]  quad;
    longint      x, y, z, t;
    int          i;
    biased = turn + 32'h2000_0000;
    quad   = biased[31:30];
    resid  = turn - {quad, 30'd0};
    z      = longint'($signed(resid));
    x      = 64'sd652032874;
    y      = 0;
    for (i = 0; i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_units[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_units[i];
      end
      x = t;
    end
    case (quad)
      2'd0: begin cos_v = x;  sin_v = y;  end
      2'd1: begin cos_v = -y; sin_v = x;  end
      2'd2: begin cos_v = -x; sin_v = -y; end
      default: begin cos_v = y; sin_v = -x; end
    endcase
  endfunction

  // 31 fraction bits down to the output grid, halves up, clamped to 18 bits
  function automatic logic signed [rqc_pkg::OUT_W-1:0] round_to_coord(input longint acc);
    longint r;
    r = (acc + 64'sd1073741824) >>> 31;
    if (r > 131071)
      r = 131071;
    else if (r < -131072)
      r = -131072;
    return r[rqc_pkg::OUT_W-1:0];
  endfunction

  function automatic void predict_corners(input logic signed [rqc_pkg::COORD_W-1:0] cx,
                                          input logic signed [rqc_pkg::COORD_W-1:0] cy,
                                          input logic [ANG_W-1:0] rot);
    longint       c, s, w, h, sw, sh, cxl, cyl;
    logic [31:0]  turn;
    corner_beat_t beat;
    int           k;
    turn = 32'(rot) << (32 - ANG_W);
    cordic_sin_cos(turn, c, s);
    w   = width_q;
    h   = height_q;
    cxl = cx;
    cyl = cy;
    for (k = 0; k < 4; k++) begin
      sw        = k[0] ? w : -w;
      sh        = k[1] ? h : -h;
      beat.idx  = rqc_pkg::corner_t'(k[1:0]);
      beat.x    = round_to_coord((cxl <<< 31) + sw * c + sh * s);
      beat.y    = round_to_coord((cyl <<< 31) + sh * c - sw * s);
      beat.last = (k == 3);
      corners_expected.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_q  = '0;
      height_q = '0;
      corners_expected.delete();
    end else begin
      if (cfg_we) begin
        case (rqc_pkg::cfg_reg_t'(cfg_addr))
          rqc_pkg::REG_RECT_WIDTH:  width_q  = cfg_wdata;
          rqc_pkg::REG_RECT_HEIGHT: height_q = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_corners(in_center_x, in_center_y, in_rotation);
        items_seen++;
      end
      if (out_valid === 1'b1) begin
        beats_seen++;
        if (corners_expected.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected corner beat: expected none, got idx %0d x %0d y %0d last %0b",
                   $time, out_corner_index, out_corner_x, out_corner_y, out_last_corner);
        end else begin
          want = corners_expected.pop_front();
          if (out_corner_index !== want.idx || out_corner_x !== want.x ||
              out_corner_y !== want.y || out_last_corner !== want.last) begin
            fail_count++;
            $display("%0t: corner mismatch: expected idx %0d x %0d y %0d last %0b, ",
                     $time, want.idx, want.x, want.y, want.last,
                     "got idx %0d x %0d y %0d last %0b",
                     out_corner_index, out_corner_x, out_corner_y, out_last_corner);
          end
        end
      end else if (out_valid !== 1'b0) begin
        fail_count++;
        $display("%0t: out_valid unknown: expected 0 or 1, got %b", $time, out_valid);
      end
    end
    corners_due = corners_expected.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for rotated_quad_corners_core: clock, reset, size writes and centre/angle items.
// Depends on rqc_pkg and rqc_corner_checker, which predicts and checks the corner beats.
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 54;

  logic                                clk   = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic signed [rqc_pkg::COORD_W-1:0]  in_center_x = '0;
  logic signed [rqc_pkg::COORD_W-1:0]  in_center_y = '0;
  logic [rqc_pkg::ANGLE_BITS_DEF-1:0]  in_rotation = '0;
  logic                                out_valid;
  logic [1:0]                          out_corner_index;
  logic signed [rqc_pkg::OUT_W-1:0]    out_corner_x;
  logic signed [rqc_pkg::OUT_W-1:0]    out_corner_y;
  logic                                out_last_corner;
  logic                                cfg_we    = 1'b0;
  logic [0:0]                          cfg_addr  = '0;
  logic [rqc_pkg::SIZE_W-1:0]          cfg_wdata = '0;

  int fail_count, corners_due, items_seen, beats_seen;
  int quiet_cycles  = 0;
  int settings_used = 0;
  bit no_idle       = 1'b0;

  // quadrant and half-quadrant boundaries plus the ends of the angle range
  logic [15:0] boundary_turns [11] = '{
    16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001,
    16'h1FFF, 16'h2000, 16'h6000, 16'hA000, 16'hE000
  };

  always #5 clk = ~clk;

  rotated_quad_corners_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_rotation      (in_rotation),
    .out_valid        (out_valid),
    .out_corner_index (out_corner_index),
    .out_corner_x     (out_corner_x),
    .out_corner_y     (out_corner_y),
    .out_last_corner  (out_last_corner),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  rqc_corner_checker corner_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_rotation      (in_rotation),
    .out_valid        (out_valid),
    .out_corner_index (out_corner_index),
    .out_corner_x     (out_corner_x),
    .out_corner_y     (out_corner_y),
    .out_last_corner  (out_last_corner),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .corners_due      (corners_due),
    .items_seen       (items_seen),
    .beats_seen       (beats_seen)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles at %0t", quiet_cycles, $time);
      $display("simulation failed");
      $finish;
    end
  end

  // mostly back-to-back or short pauses, now and then a long one
  function automatic int idle_len();
    int roll;
    if (no_idle)
      return 0;
    roll = $urandom_range(99);
    if (roll < 50)
      return 0;
    if (roll < 85)
      return $urandom_range(3, 1);
    if (roll < 96)
      return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  task automatic apply_size(input logic [rqc_pkg::SIZE_W-1:0] w,
                            input logic [rqc_pkg::SIZE_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_addr  <= rqc_pkg::REG_RECT_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_addr  <= rqc_pkg::REG_RECT_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // called at a falling edge; returns at the falling edge after the accept
  task automatic issue_item(input logic signed [rqc_pkg::COORD_W-1:0] cx,
                            input logic signed [rqc_pkg::COORD_W-1:0] cy,
                            input logic [rqc_pkg::ANGLE_BITS_DEF-1:0] rot);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      start       <= 1'b0;
      in_center_x <= 16'($urandom);
      in_center_y <= 16'($urandom);
      in_rotation <= 16'($urandom);
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    in_center_x <= cx;
    in_center_y <= cy;
    in_rotation <= rot;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (corners_due != 0) @(negedge clk);
  endtask

  task automatic random_items(input int count);
    logic signed [rqc_pkg::COORD_W-1:0] cx, cy;
    logic [rqc_pkg::ANGLE_BITS_DEF-1:0] rot;
    int                                 pick;
    repeat (count) begin
      pick = $urandom_range(9);
      cx   = 16'($urandom);
      cy   = 16'($urandom);
      rot  = 16'($urandom);
      if (pick == 0)
        rot = 16'($urandom_range(3)) << 14;
      else if (pick == 1)
        rot = (16'($urandom_range(3)) << 14) + 16'h2000 + 16'($urandom_range(4)) - 16'd2;
      else if (pick == 2) begin
        cx = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        cy = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
      issue_item(cx, cy, rot);
    end
  endtask

  initial begin
    int n, phase;
    logic [rqc_pkg::SIZE_W-1:0] w, h;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sizes still zero from reset: every corner sits on the centre
    issue_item(16'sh1234, -16'sh0567, 16'h1357);
    issue_item(16'sh7FFF, 16'sh8000, 16'hFFFF);
    issue_item(16'sh8000, 16'sh7FFF, 16'h4000);
    wait_idle();

    apply_size(16'hFFFF, 16'hFFFF);
    for (n = 0; n < 11; n++)
      issue_item(n[0] ? 16'sh7FFF : 16'sh8000, n[1] ? 16'sh8000 : 16'sh7FFF,
                 boundary_turns[n]);
    wait_idle();

    apply_size(16'hFFFF, 16'h0000);
    issue_item(16'sh0000, 16'sh0000, 16'h2AAA);
    issue_item(16'sh8000, 16'sh8000, 16'h9000);
    wait_idle();

    apply_size(16'h0000, 16'hFFFF);
    issue_item(16'sh0000, 16'sh0000, 16'h2AAA);
    issue_item(16'sh7FFF, 16'sh7FFF, 16'hD555);
    wait_idle();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin w = 16'($urandom); h = 16'($urandom); end
        1: begin w = 16'hFFFF; h = 16'hFFFF; end
        2: begin w = 16'h0001; h = 16'h0001; end
        3: begin w = 16'h0000; h = 16'($urandom); end
        4: begin w = 16'($urandom); h = 16'h0000; end
        default: begin w = 16'($urandom_range(255)); h = 16'($urandom_range(255)); end
      endcase
      // two phases run without pauses on the input side
      no_idle = (phase == 1 || phase == 4);
      apply_size(w, h);
      random_items(PHASE_ITEMS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d items over %0d rectangle sizes, zero, unit and full-scale included",
             items_seen, settings_used);
    $display("checked %0d corner beats, %0d failures", beats_seen, fail_count);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
